// ===== hdl/sha256_message_hasher_assert.svh =====
// assertion macros for the sha256 message hasher
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// implication checked on every edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;
	typedef logic [31:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} item_t;

	localparam int unsigned QueueDepth = 4;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t ror(input word_t x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ===== hdl/sha_front.sv =====
`timescale 1ns / 1ps
// input queue: drops empty items
module sha_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  sha_pkg::item_t item_in,
	output logic           q_valid,
	input  logic           q_take,
	output sha_pkg::item_t q_item
);
	localparam int unsigned Aw = $clog2(sha_pkg::QueueDepth);

	sha_pkg::item_t mem_q [sha_pkg::QueueDepth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0]   cnt_q;
	logic          wr_en, rd_en;

	assign full    = (cnt_q == (Aw+1)'(sha_pkg::QueueDepth));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];
	assign wr_en   = push && !full && (item_in.has_byte || item_in.end_of_message);
	assign rd_en   = q_valid && q_take;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
		end
	end
endmodule

// ===== hdl/sha_back.sv =====
`timescale 1ns / 1ps
`include "sha256_message_hasher_assert.svh"
// byte packing, padding, one round per cycle, digest output
module sha_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_take,
	input  sha_pkg::item_t q_item,
	output logic           empty,
	input  logic           pop,
	output logic [31:0]    digest_word,
	output logic [2:0]     word_index,
	output logic           last_word
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_LEN  = 6'b000100,
		ST_RND  = 6'b001000,
		ST_ADD  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t            st_q;
	sha_pkg::word_t    blk_q [16];
	sha_pkg::word_t    w_q [16];
	sha_pkg::word_t    v_q [8];
	sha_pkg::word_t    h_q [8];
	logic [63:0]       len_q;
	logic [5:0]        fill_q;
	logic [5:0]        rnd_q;
	logic              fin_q;
	logic              lenblk_q;
	logic [2:0]        oidx_q;

	sha_pkg::word_t w_new, w_cur, s1, ch, s0, mj, t1, t2;
	logic [1:0] bp;
	logic [3:0] wi;

	assign bp = fill_q[1:0];
	assign wi = fill_q[5:2];

	always_comb begin
		w_new = (sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10))
			+ w_q[9] + (sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[0];
		w_cur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : w_new;
		s1 = sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11) ^ sha_pkg::ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + sha_pkg::RoundK[rnd_q] + w_cur;
		s0 = sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^ sha_pkg::ror(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
	end

	assign q_take      = (st_q == ST_IDLE) && q_valid;
	assign empty       = (st_q != ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.has_byte) begin
						if (bp == 2'd0) blk_q[wi] <= {q_item.data_byte, 24'd0};
						else blk_q[wi][8'(3 - bp) * 8 +: 8] <= q_item.data_byte;
					end else if (bp == 2'd0) blk_q[wi] <= 32'd0;
					if (q_item.has_byte && fill_q == 6'd63) begin
						for (int i = 0; i < 15; i++) w_q[i] <= blk_q[i];
						w_q[15] <= {blk_q[15][31:8], q_item.data_byte};
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
			end
			ST_PAD: begin
				// pad byte goes into a word that is already cleared
				blk_q[wi][8'(3 - bp) * 8 +: 8] <= 8'h80;
				for (int i = 0; i < 16; i++) begin
					if (4'(i) > wi) blk_q[i] <= 32'd0;
				end
				if (bp == 2'd0) begin
					blk_q[wi] <= 32'h80000000;
				end
				if (fill_q > 6'd55) begin
					for (int i = 0; i < 16; i++) begin
						if (4'(i) < wi) w_q[i] <= blk_q[i];
						else if (4'(i) > wi) w_q[i] <= 32'd0;
					end
					w_q[wi] <= (bp == 2'd0) ? 32'h80000000
						: (blk_q[wi] | (32'h80 << (8'(3 - bp) * 8)));
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
				end
			end
			ST_LEN: begin
				for (int i = 0; i < 14; i++) w_q[i] <= lenblk_q ? 32'd0 : blk_q[i];
				w_q[14] <= len_q[63:32];
				w_q[15] <= len_q[31:0];
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			ST_RND: begin
				if (rnd_q >= 6'd16) begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
				end
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			len_q    <= '0;
			fill_q   <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			lenblk_q <= 1'b0;
			oidx_q   <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.has_byte) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'd8;
						end
						fin_q <= 1'b0;
						rnd_q <= '0;
						if (q_item.has_byte && fill_q == 6'd63) begin
							fin_q <= q_item.end_of_message;
							st_q  <= ST_RND;
						end else if (q_item.end_of_message) begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// 55 bytes or fewer: length fits this block
					rnd_q    <= '0;
					lenblk_q <= (fill_q > 6'd55);
					st_q     <= (fill_q > 6'd55) ? ST_RND : ST_LEN;
					fin_q    <= (fill_q > 6'd55);
				end
				ST_LEN: begin
					rnd_q    <= '0;
					fin_q    <= 1'b0;
					lenblk_q <= 1'b1;
					st_q     <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					lenblk_q <= fin_q;
					if (fin_q) begin
						// message ended: pad goes in fresh block, else length block follows
						st_q <= (fill_q == 6'd0 && !lenblk_q) ? ST_PAD : ST_LEN;
						if (lenblk_q) fill_q <= 6'd0;
					end else if (!lenblk_q) begin
						st_q <= ST_IDLE;
					end else begin
						st_q   <= ST_OUT;
						oidx_q <= '0;
					end
				end
				ST_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							st_q   <= ST_IDLE;
							fill_q <= '0;
							len_q  <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_onehot, 1'b1, $onehot(st_q), "state not one-hot")
	`SHA_ASSERT_IMP(a_take_idle, q_take, st_q == ST_IDLE, "item taken while busy")
	`SHA_ASSERT_NXT(a_out_last, st_q == ST_OUT && pop && oidx_q == 3'd7,
		st_q == ST_IDLE && fill_q == 6'd0, "digest end did not reset")
endmodule

// ===== hdl/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// sha-256 over a byte stream: a 4-entry input queue feeds the round engine
// bytes are absorbed one per cycle while idle; a full block then holds input through its rounds and the add
// no byte is taken while a block is hashed; the next byte is taken after the add
// end of message: the pad state, the length block, its rounds and the add come before the first digest word,
// with a second block of rounds and add when the length does not fit, then 8 words
// arst_n clears queue, lengths and loads the initial hash
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	sha_pkg::item_t item_in, q_item;
	logic q_valid, q_take;

	assign item_in = '{data_byte: data_byte, has_byte: has_byte,
		end_of_message: end_of_message};

	sha_front u_front (.clk, .arst_n, .push, .full, .item_in, .q_valid, .q_take, .q_item);

	sha_back u_back (.clk, .arst_n, .q_valid, .q_take, .q_item, .empty, .pop,
		.digest_word, .word_index, .last_word);
endmodule
